FILE: rtl/acdt_pkg.sv
// Shared package of the audio coprocessor DAC/timer unit.
// Holds mode and register codes, sizes and the request/result/config types.
// No dependencies.
package acdt_pkg;

	// request modes
	localparam logic [2:0] MODE_RESET      = 3'd0;
	localparam logic [2:0] MODE_NMI        = 3'd1;
	localparam logic [2:0] MODE_RATE       = 3'd2;
	localparam logic [2:0] MODE_HOST_WRITE = 3'd3;
	localparam logic [2:0] MODE_CPU_WRITE  = 3'd4;
	localparam logic [2:0] MODE_READ       = 3'd5;
	localparam logic [2:0] MODE_TICK       = 3'd6;

	// configuration register indexes
	localparam logic [1:0] CFG_CLOCKS = 2'd0;
	localparam logic [1:0] CFG_VOLUME = 2'd1;
	localparam logic [1:0] CFG_MUTED  = 2'd2;
	localparam logic [1:0] CFG_PAUSED = 2'd3;

	localparam int RAM_BYTES_DEF = 4096;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [10:0] CLOCKS_RST = 11'd81;
	localparam logic [7:0]  VOLUME_RST = 8'd255;
	localparam logic [15:0] DAC_SEL    = 16'h8000;

	// decoded request class, one flag per action
	typedef struct packed {
		logic reset_reg;
		logic nmi;
		logic rate;
		logic mem_wr;
		logic dac_load;
		logic mem_rd;
		logic tick;
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] address;
		logic [7:0]  data;
	} item_t;

	typedef struct packed {
		logic [7:0]        read_data;
		logic signed [15:0] sample;
		logic              irq_pulse;
		logic              nmi_pulse;
		logic              cpu_reset_pulse;
		logic [9:0]        run_cycles;
	} result_t;

	typedef struct packed {
		logic [10:0] clocks;
		logic [7:0]  volume;
		logic        muted;
		logic        paused;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_stat_t;

endpackage

FILE: rtl/acdt_front.sv
// Front end: accepts requests and classifies the mode into action flags.
// Depends on acdt_pkg.
module acdt_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        mode,
	input  logic [15:0]       address,
	input  logic [7:0]        data,
	input  logic              q_full,
	input  logic              clr_busy,
	output logic              push,
	output acdt_pkg::item_t   push_item
);
	import acdt_pkg::*;

	op_t op;

	always_comb begin
		op = '0;
		case (mode)
			MODE_RESET:      op.reset_reg = 1'b1;
			MODE_NMI:        op.nmi = 1'b1;
			MODE_RATE:       op.rate = 1'b1;
			MODE_HOST_WRITE: op.mem_wr = 1'b1;
			MODE_CPU_WRITE: begin
				op.mem_wr = 1'b1;
				op.dac_load = |(address & DAC_SEL);
			end
			MODE_READ:       op.mem_rd = 1'b1;
			MODE_TICK:       op.tick = 1'b1;
			default:         op = '0;
		endcase
	end

	// hold off while the queue is full or the RAM is being cleared
	assign in_ready = !q_full && !clr_busy;
	assign push = in_valid && in_ready;
	assign push_item = '{op: op, address: address, data: data};

endmodule

FILE: rtl/acdt_queue.sv
// Short request queue between front and back ends.
// Depends on acdt_pkg.
module acdt_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  acdt_pkg::item_t     push_item,
	input  logic                pop,
	output acdt_pkg::item_t     head,
	output acdt_pkg::q_stat_t   stat
);
	import acdt_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

	item_t         slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	assign head = slot_q[rd_ptr_q];
	assign stat.valid = (count_q != '0);
	assign stat.full = (count_q == CW'(QUEUE_DEPTH));

endmodule

FILE: rtl/acdt_back.sv
// Back end: timer/DAC state, shared RAM with clearing pass, result pipeline.
// Depends on acdt_pkg.
module acdt_back #(
	parameter int RAM_BYTES = acdt_pkg::RAM_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  acdt_pkg::cfg_t      cfg,
	input  acdt_pkg::q_stat_t   q_stat,
	input  acdt_pkg::item_t     head,
	output logic                pop,
	output logic                clr_busy,
	output logic                out_valid,
	input  logic                out_ready,
	output acdt_pkg::result_t   res
);
	import acdt_pkg::*;

	localparam int AW = $clog2(RAM_BYTES);

	// architectural state
	logic [7:0]         dac_q;
	logic [7:0]         rate_q;
	logic               running_q;
	logic               pend_q;
	logic signed [15:0] cd_q;

	// RAM and clearing sweep
	logic [7:0]    ram_q [RAM_BYTES];
	logic [7:0]    ram_rd_q;
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	// pipeline
	logic    vld_s1;
	logic    is_read_s1;
	result_t res_s1;
	logic    out_valid_q;
	result_t res_q;
	result_t res_fwd;

	logic               s1_adv;
	logic               tick_act;
	logic [AW-1:0]      idx;
	logic signed [8:0]  centered;
	logic signed [17:0] prod;
	logic signed [15:0] smp;
	logic signed [17:0] cd_sub;
	logic signed [15:0] cd_sat;
	logic signed [15:0] cd_add;
	logic               expire;
	result_t            res_new;

	assign s1_adv = vld_s1 && (!out_valid_q || out_ready);
	assign pop = q_stat.valid && (!vld_s1 || s1_adv) && !clr_busy_q;
	assign idx = head.address[AW-1:0];
	assign tick_act = head.op.tick && !cfg.paused;

	always_comb begin
		centered = $signed({1'b0, dac_q}) - 9'sd128;
		prod = 18'(centered) * $signed({10'd0, cfg.volume});
		if (prod > 18'sd32767) begin
			smp = 16'sh7FFF;
		end else if (prod < -18'sd32768) begin
			smp = 16'sh8000;
		end else begin
			smp = prod[15:0];
		end
		cd_sub = 18'(cd_q) - $signed({7'd0, cfg.clocks});
		cd_sat = (cd_sub < -18'sd32768) ? 16'sh8000 : cd_sub[15:0];
		expire = cd_sat[15];
		cd_add = cd_sat + $signed({8'd0, rate_q});

		res_new = '0;
		if (head.op.nmi) begin
			res_new.nmi_pulse = 1'b1;
			res_new.run_cycles = {rate_q, 2'b00};
		end
		if (tick_act) begin
			res_new.sample = cfg.muted ? 16'sd0 : smp;
			if (expire) begin
				res_new.cpu_reset_pulse = pend_q;
				if (running_q) begin
					res_new.irq_pulse = 1'b1;
					res_new.run_cycles = {rate_q, 2'b00};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dac_q      <= '0;
			rate_q     <= '0;
			running_q  <= 1'b0;
			pend_q     <= 1'b0;
			cd_q       <= '0;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == '1) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (pop) begin
				if (head.op.reset_reg) begin
					pend_q <= 1'b1;
					cd_q   <= 16'sd255;
				end
				if (head.op.rate) begin
					rate_q    <= {head.data[6:0], head.data[0]};
					running_q <= head.data[7];
				end
				if (head.op.dac_load) begin
					dac_q <= head.data;
				end
				if (tick_act) begin
					cd_q <= expire ? cd_add : cd_sat;
					if (expire) begin
						pend_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			ram_q[clr_addr_q] <= '0;
		end else if (pop && head.op.mem_wr) begin
			ram_q[idx] <= head.data;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.op.mem_rd) begin
			ram_rd_q <= ram_q[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				vld_s1 <= 1'b1;
			end else if (s1_adv) begin
				vld_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// merge the registered RAM byte into the staged result
	always_comb begin
		res_fwd = res_s1;
		res_fwd.read_data = is_read_s1 ? ram_rd_q : 8'd0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_s1     <= res_new;
			is_read_s1 <= head.op.mem_rd;
		end
		if (s1_adv) begin
			res_q <= res_fwd;
		end
	end

	assign clr_busy = clr_busy_q;
	assign out_valid = out_valid_q;
	assign res = res_q;

`ifndef SYNTHESIS
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !pop) else $error("request popped during RAM clear");
	a_cd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cd_q <= 16'sd255) else $error("countdown above reset load");
	a_pend_fell: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(pend_q) |-> $past(pop && tick_act && expire))
		else $error("pending reset dropped without expiry");
	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !s1_adv |=> vld_s1 && (ram_rd_q === $past(ram_rd_q)))
		else $error("read data lost while stage stalled");
	a_s1_full: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !s1_adv |-> !pop) else $error("stage overwritten while stalled");
`endif

endmodule

FILE: rtl/audio_coprocessor_dac_timer_unit.sv
// Top level of the audio coprocessor DAC/timer unit: config registers,
// front end, request queue and back end. Depends on acdt_pkg, acdt_front,
// acdt_queue and acdt_back.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------
//  request  | in_valid / in_ready      | mode, address, data
//  result   | out_valid / out_ready    | read_data, sample, irq_pulse,
//           |                          | nmi_pulse, cpu_reset_pulse, run_cycles
//  config   | cfg_we (no wait)         | cfg_index, cfg_data
//
// One request per cycle sustained while out_ready is high and no RAM clear runs;
// a request popped from the queue passes through one execute stage, set by the
// registered RAM read, then the output register.
// After reset the shared RAM is swept to zero, one byte per cycle, and
// in_ready stays low until the sweep ends; config writes are taken meanwhile.
// A stalled result holds the output register; the execute stage and the
// two-entry queue absorb further requests before in_ready drops.
module audio_coprocessor_dac_timer_unit #(
	parameter int RAM_BYTES = acdt_pkg::RAM_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         mode,
	input  logic [15:0]        address,
	input  logic [7:0]         data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         read_data,
	output logic signed [15:0] sample,
	output logic               irq_pulse,
	output logic               nmi_pulse,
	output logic               cpu_reset_pulse,
	output logic [9:0]         run_cycles,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [10:0]        cfg_data
);
	import acdt_pkg::*;

	cfg_t    cfg_q;
	item_t   push_item;
	item_t   head;
	q_stat_t q_stat;
	result_t res;
	logic    push;
	logic    pop;
	logic    clr_busy;

	// config registers: the user must write them only while the unit is idle; the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clocks <= CLOCKS_RST;
			cfg_q.volume <= VOLUME_RST;
			cfg_q.muted  <= 1'b0;
			cfg_q.paused <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CLOCKS: cfg_q.clocks <= cfg_data;
				CFG_VOLUME: cfg_q.volume <= cfg_data[7:0];
				CFG_MUTED:  cfg_q.muted  <= cfg_data[0];
				CFG_PAUSED: cfg_q.paused <= cfg_data[0];
				default:    cfg_q <= cfg_q;
			endcase
		end
	end

	// classify requests and push them into the queue
	acdt_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.address   (address),
		.data      (data),
		.q_full    (q_stat.full),
		.clr_busy  (clr_busy),
		.push      (push),
		.push_item (push_item)
	);

	// decouple acceptance from execution
	acdt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	// execute: timer, DAC, RAM and result registers
	acdt_back #(
		.RAM_BYTES (RAM_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_stat    (q_stat),
		.head      (head),
		.pop       (pop),
		.clr_busy  (clr_busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign read_data       = res.read_data;
	assign sample          = res.sample;
	assign irq_pulse       = res.irq_pulse;
	assign nmi_pulse       = res.nmi_pulse;
	assign cpu_reset_pulse = res.cpu_reset_pulse;
	assign run_cycles      = res.run_cycles;

endmodule
